>>> design/rvdx_pkg.sv
`timescale 1ns / 1ps

package rvdx_pkg;

   // Major opcodes
   localparam logic [6:0] OPC_LOAD   = 7'h03;
   localparam logic [6:0] OPC_ALUI   = 7'h13;
   localparam logic [6:0] OPC_STORE  = 7'h23;
   localparam logic [6:0] OPC_ALUR   = 7'h33;
   localparam logic [6:0] OPC_LUI    = 7'h37;
   localparam logic [6:0] OPC_BRANCH = 7'h63;
   localparam logic [6:0] OPC_JALR   = 7'h67;
   localparam logic [6:0] OPC_JAL    = 7'h6F;

   // funct7 codes
   localparam logic [6:0] F7_BASE = 7'h00;
   localparam logic [6:0] F7_ALT  = 7'h20;
   localparam logic [6:0] F7_MULD = 7'h01;

   // Status codes
   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_ILLEGAL = 2'd1;
   localparam logic [1:0] ST_DIVZERO = 2'd2;

   localparam int XLEN      = 32;
   localparam int DIV_STEPS = XLEN;

   // What the later stages still have to do with a beat
   typedef enum logic [2:0] {
      K_PLAIN  = 3'd0,
      K_MUL    = 3'd1,
      K_MULH   = 3'd2,
      K_MULHSU = 3'd3,
      K_MULHU  = 3'd4,
      K_DIV    = 3'd5,
      K_REM    = 3'd6,
      K_REMU   = 3'd7
   } kind_type;

   typedef struct packed {
      logic [31:0] res;
      logic        wr;
      logic [4:0]  rd;
      logic        redir;
      logic [31:0] npc;
      logic [1:0]  status;
      kind_type    kind;
      logic [31:0] opa;
      logic [31:0] opb;
      logic [63:0] prod;
      logic [31:0] rem;
      logic [31:0] quo;
      logic [31:0] dvs;
      logic        neg;
   } pipe_type;

endpackage

>>> design/rvdx_decode.sv
`timescale 1ns / 1ps

module rvdx_decode (
   input  logic               clock,
   input  logic               en,
   input  logic [31:0]        instruction,
   input  logic [31:0]        src1_data,
   input  logic [31:0]        src2_data,
   input  logic [31:0]        pc_value,
   output rvdx_pkg::pipe_type out_ff
);
   import rvdx_pkg::*;

   pipe_type    out_in;
   logic [6:0]  opc;
   logic [2:0]  f3;
   logic [6:0]  f7;
   logic [31:0] imm_i, imm_s, imm_b, imm_j;
   logic [31:0] sum_i, pc4, opnd;
   logic [4:0]  shamt;
   logic [31:0] abs_a, abs_b;

   assign opc   = instruction[6:0];
   assign f3    = instruction[14:12];
   assign f7    = instruction[31:25];
   assign imm_i = {{20{instruction[31]}}, instruction[31:20]};
   assign imm_s = {{20{instruction[31]}}, instruction[31:25], instruction[11:7]};
   assign imm_b = {{19{instruction[31]}}, instruction[31], instruction[7],
                   instruction[30:25], instruction[11:8], 1'b0};
   assign imm_j = {{11{instruction[31]}}, instruction[31], instruction[19:12],
                   instruction[20], instruction[30:21], 1'b0};
   assign sum_i = src1_data + imm_i;
   assign pc4   = pc_value + 32'd4;
   assign opnd  = (opc == OPC_ALUI) ? imm_i : src2_data;
   assign shamt = (opc == OPC_ALUI) ? instruction[24:20] : src2_data[4:0];
   assign abs_a = src1_data[31] ? (32'd0 - src1_data) : src1_data;
   assign abs_b = src2_data[31] ? (32'd0 - src2_data) : src2_data;

   // Decode and simple ALU
   always_comb begin
      out_in        = '0;
      out_in.rd     = instruction[11:7];
      out_in.npc    = pc4;
      out_in.status = ST_OK;
      out_in.kind   = K_PLAIN;
      out_in.opa    = src1_data;
      out_in.opb    = src2_data;
      case (opc)
         OPC_LUI: begin
            out_in.res = {instruction[31:12], 12'd0};
            out_in.wr  = 1'b1;
         end
         OPC_JAL: begin
            out_in.res   = pc4;
            out_in.wr    = 1'b1;
            out_in.redir = 1'b1;
            out_in.npc   = pc_value + imm_j;
         end
         OPC_JALR: begin
            if (f3 != 3'd0) begin
               out_in.status = ST_ILLEGAL;
            end else begin
               out_in.res   = sum_i;
               out_in.redir = 1'b1;
               out_in.npc   = {sum_i[31:1], 1'b0};
            end
         end
         OPC_LOAD: begin
            if (f3 > 3'd2) out_in.status = ST_ILLEGAL;
            else out_in.res = sum_i;
         end
         OPC_STORE: begin
            if (f3 > 3'd2) out_in.status = ST_ILLEGAL;
            else out_in.res = src1_data + imm_s;
         end
         OPC_BRANCH: begin
            if (f3 > 3'd1) begin
               out_in.status = ST_ILLEGAL;
            end else if ((f3 == 3'd0) == (src1_data == src2_data)) begin
               out_in.redir = 1'b1;
               out_in.npc   = pc_value + imm_b;
            end
         end
         OPC_ALUI, OPC_ALUR: begin
            out_in.wr = 1'b1;
            if (opc == OPC_ALUR && f7 == F7_MULD) begin
               // multiply / divide group
               case (f3)
                  3'd0: out_in.kind = K_MUL;
                  3'd1: out_in.kind = K_MULH;
                  3'd2: out_in.kind = K_MULHSU;
                  3'd3: out_in.kind = K_MULHU;
                  3'd4: out_in.kind = K_DIV;
                  3'd6: out_in.kind = K_REM;
                  3'd7: out_in.kind = K_REMU;
                  default: out_in.status = ST_ILLEGAL;
               endcase
               if (f3[2] && f3 != 3'd5 && src2_data == 32'd0)
                  out_in.status = ST_DIVZERO;
               out_in.quo = (f3 == 3'd7) ? src1_data : abs_a;
               out_in.dvs = (f3 == 3'd7) ? src2_data : abs_b;
               out_in.neg = (f3 == 3'd4) ? (src1_data[31] ^ src2_data[31])
                                         : src1_data[31];
            end else if (opc == OPC_ALUR && f7 == F7_ALT) begin
               if (f3 == 3'd0) out_in.res = src1_data - src2_data;
               else if (f3 == 3'd5) out_in.res = 32'($signed(src1_data) >>> shamt);
               else out_in.status = ST_ILLEGAL;
            end else if (opc == OPC_ALUR && f7 != F7_BASE) begin
               out_in.status = ST_ILLEGAL;
            end else begin
               case (f3)
                  3'd0: out_in.res = src1_data + opnd;
                  3'd1: begin
                     if (f7 != F7_BASE) out_in.status = ST_ILLEGAL;
                     else out_in.res = src1_data << shamt;
                  end
                  3'd2: out_in.res = {31'd0, $signed(src1_data) < $signed(opnd)};
                  3'd3: out_in.res = {31'd0, src1_data < opnd};
                  3'd4: out_in.res = src1_data ^ opnd;
                  3'd5: begin
                     if (f7 == F7_BASE) out_in.res = src1_data >> shamt;
                     else if (f7 == F7_ALT) out_in.res = 32'($signed(src1_data) >>> shamt);
                     else out_in.status = ST_ILLEGAL;
                  end
                  3'd6: out_in.res = src1_data | opnd;
                  default: out_in.res = src1_data & opnd;
               endcase
            end
         end
         default: out_in.status = ST_ILLEGAL;
      endcase
      // any failure squashes the effects
      if (out_in.status != ST_OK) begin
         out_in.res   = '0;
         out_in.wr    = 1'b0;
         out_in.redir = 1'b0;
         out_in.npc   = pc4;
         out_in.kind  = K_PLAIN;
      end
   end

   always_ff @(posedge clock) begin
      if (en) out_ff <= out_in;
   end

endmodule

>>> design/rvdx_mul.sv
`timescale 1ns / 1ps

module rvdx_mul (
   input  logic               clock,
   input  logic               en_prod,
   input  logic               en_fix,
   input  rvdx_pkg::pipe_type in_data,
   output rvdx_pkg::pipe_type prod_ff,
   output rvdx_pkg::pipe_type fix_ff
);
   import rvdx_pkg::*;

   pipe_type    prod_in, fix_in;
   logic [31:0] hu, corr_a, corr_b;

   // Stage one: unsigned 32x32 product
   always_comb begin
      prod_in      = in_data;
      prod_in.prod = 64'(in_data.opa) * 64'(in_data.opb);
   end

   // Stage two: pick the half and apply signed corrections
   assign hu     = prod_ff.prod[63:32];
   assign corr_a = prod_ff.opa[31] ? prod_ff.opb : 32'd0;
   assign corr_b = prod_ff.opb[31] ? prod_ff.opa : 32'd0;

   always_comb begin
      fix_in = prod_ff;
      case (prod_ff.kind)
         K_MUL:    fix_in.res = prod_ff.prod[31:0];
         K_MULH:   fix_in.res = hu - corr_a - corr_b;
         K_MULHSU: fix_in.res = hu - corr_a;
         K_MULHU:  fix_in.res = hu;
         default:  fix_in.res = prod_ff.res;
      endcase
   end

   always_ff @(posedge clock) begin
      if (en_prod) prod_ff <= prod_in;
      if (en_fix) fix_ff <= fix_in;
   end

endmodule

>>> design/rvdx_div_step.sv
`timescale 1ns / 1ps

module rvdx_div_step (
   input  logic               clock,
   input  logic               en,
   input  rvdx_pkg::pipe_type in_data,
   output rvdx_pkg::pipe_type out_ff
);
   import rvdx_pkg::*;

   pipe_type    out_in;
   logic [32:0] trial;
   logic [33:0] diff;

   // One restoring quotient bit
   assign trial = {in_data.rem, in_data.quo[31]};
   assign diff  = {1'b0, trial} - {2'b00, in_data.dvs};

   always_comb begin
      out_in = in_data;
      if (!diff[33]) begin
         out_in.rem = diff[31:0];
         out_in.quo = {in_data.quo[30:0], 1'b1};
      end else begin
         out_in.rem = trial[31:0];
         out_in.quo = {in_data.quo[30:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (en) out_ff <= out_in;
   end

endmodule

>>> design/rv32im_decode_execute_unit.sv
`timescale 1ns / 1ps

// RV32IM decode/execute unit. Accepts one instruction beat per clock and
// returns one result beat per instruction, in order. Every instruction
// passes through one decode stage, two multiplier stages, 32 divider
// stages (one restoring quotient bit each) and the output register. Each
// stage holds its beat only while the stage after it is full and stalled, so
// bubbles close up and req_ready drops only when every stage holds a beat
// and rsp_ready is low.
module rv32im_decode_execute_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_instruction,
   input  logic [31:0] req_src1_data,
   input  logic [31:0] req_src2_data,
   input  logic [31:0] req_pc_value,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_result_value,
   output logic        rsp_writes_register,
   output logic [4:0]  rsp_dest_index,
   output logic        rsp_redirect,
   output logic [31:0] rsp_next_pc,
   output logic [1:0]  rsp_status
);
   import rvdx_pkg::*;

   localparam int NSTG = DIV_STEPS + 4;
   localparam int LAST = NSTG - 1;

   logic [NSTG-1:0] valid_ff;
   logic [NSTG-1:0] adv;
   pipe_type        stage [LAST];
   pipe_type        rsp_ff;
   pipe_type        final_in;

   // Advance chain: a stage loads when empty or when its successor loads
   always_comb begin
      adv[LAST] = !valid_ff[LAST] || rsp_ready;
      for (int i = LAST - 1; i >= 0; i--) begin
         adv[i] = !valid_ff[i] || adv[i+1];
      end
   end

   assign req_ready = adv[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (adv[0]) valid_ff[0] <= req_valid;
         for (int i = 1; i < NSTG; i++) begin
            if (adv[i]) valid_ff[i] <= valid_ff[i-1];
         end
      end
   end

   rvdx_decode u_decode (
      .clock       (clock),
      .en          (adv[0]),
      .instruction (req_instruction),
      .src1_data   (req_src1_data),
      .src2_data   (req_src2_data),
      .pc_value    (req_pc_value),
      .out_ff      (stage[0])
   );

   rvdx_mul u_mul (
      .clock   (clock),
      .en_prod (adv[1]),
      .en_fix  (adv[2]),
      .in_data (stage[0]),
      .prod_ff (stage[1]),
      .fix_ff  (stage[2])
   );

   for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
      rvdx_div_step u_step (
         .clock   (clock),
         .en      (adv[g+3]),
         .in_data (stage[g+2]),
         .out_ff  (stage[g+3])
      );
   end

   // Output stage: sign fix of quotient / remainder
   always_comb begin
      final_in = stage[LAST-1];
      case (stage[LAST-1].kind)
         K_DIV: final_in.res = stage[LAST-1].neg ? (32'd0 - stage[LAST-1].quo)
                                                 : stage[LAST-1].quo;
         K_REM: final_in.res = stage[LAST-1].neg ? (32'd0 - stage[LAST-1].rem)
                                                 : stage[LAST-1].rem;
         K_REMU: final_in.res = stage[LAST-1].rem;
         default: final_in.res = stage[LAST-1].res;
      endcase
   end

   always_ff @(posedge clock) begin
      if (adv[LAST]) rsp_ff <= final_in;
   end

   assign rsp_valid           = valid_ff[LAST];
   assign rsp_result_value    = rsp_ff.res;
   assign rsp_writes_register = rsp_ff.wr;
   assign rsp_dest_index      = rsp_ff.rd;
   assign rsp_redirect        = rsp_ff.redir;
   assign rsp_next_pc         = rsp_ff.npc;
   assign rsp_status          = rsp_ff.status;

   // Failed instructions carry no effects
   a_fail_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |->
         rsp_result_value == 32'd0 && !rsp_writes_register && !rsp_redirect)
      else $error("failed instruction has effects");

   a_redirect_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_redirect |-> rsp_status == ST_OK)
      else $error("redirect with bad status");

   // Input stalls only when the whole pipe is full and blocked
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready && valid_ff == '1)
      else $error("input stalled with room in pipe");

   a_no_status3: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status != 2'd3)
      else $error("undefined status code");

endmodule

>>> test/tb_rv32im_decode_execute_unit.sv
`timescale 1ns / 1ps

module tb_rv32im_decode_execute_unit;
   import rvdx_pkg::*;

   localparam int LATENCY   = 36;
   localparam int N_RANDOM  = 1930;
   localparam int MAX_CYC   = 400000;

   typedef struct packed {
      logic [31:0] res;
      logic        wr;
      logic [4:0]  rd;
      logic        redir;
      logic [31:0] npc;
      logic [1:0]  status;
   } exec_out_type;

   typedef struct {
      logic [31:0]  instr;
      logic [31:0]  a;
      logic [31:0]  b;
      logic [31:0]  pc;
      logic         has_exp;
      exec_out_type exp;
   } vector_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [31:0] req_instruction;
   logic [31:0] req_src1_data;
   logic [31:0] req_src2_data;
   logic [31:0] req_pc_value;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [31:0] rsp_result_value;
   logic        rsp_writes_register;
   logic [4:0]  rsp_dest_index;
   logic        rsp_redirect;
   logic [31:0] rsp_next_pc;
   logic [1:0]  rsp_status;

   exec_out_type pending_results[$];
   int           error_count;
   int           cycle_count;
   int           send_idle_pct;
   int           recv_idle_pct;
   logic         hold_rsp;
   vector_type   vectors[$];

   rv32im_decode_execute_unit u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_instruction(req_instruction), .req_src1_data(req_src1_data),
      .req_src2_data(req_src2_data), .req_pc_value(req_pc_value),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_result_value(rsp_result_value),
      .rsp_writes_register(rsp_writes_register),
      .rsp_dest_index(rsp_dest_index), .rsp_redirect(rsp_redirect),
      .rsp_next_pc(rsp_next_pc), .rsp_status(rsp_status)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Immediate decoders
   function automatic logic [31:0] imm_i(logic [31:0] w);
      return {{20{w[31]}}, w[31:20]};
   endfunction
   function automatic logic [31:0] imm_s(logic [31:0] w);
      return {{20{w[31]}}, w[31:25], w[11:7]};
   endfunction
   function automatic logic [31:0] imm_b(logic [31:0] w);
      return {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
   endfunction
   function automatic logic [31:0] imm_j(logic [31:0] w);
      return {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
   endfunction

   // Expected execute result for one instruction
   function automatic exec_out_type execute_instr(logic [31:0] w, logic [31:0] a,
                                                  logic [31:0] b, logic [31:0] pc);
      exec_out_type o;
      logic [2:0]  f3;
      logic [6:0]  f7;
      logic [4:0]  sh;
      logic [63:0] p;
      logic [31:0] ua, ub, q, r;
      f3 = w[14:12];
      f7 = w[31:25];
      sh = w[24:20];
      o.res = '0; o.wr = 1'b0; o.redir = 1'b0; o.npc = pc + 32'd4;
      o.status = ST_OK; o.rd = w[11:7];
      case (w[6:0])
         OPC_LUI: begin
            o.res = {w[31:12], 12'h000}; o.wr = 1'b1;
         end
         OPC_JAL: begin
            o.res = pc + 32'd4; o.wr = 1'b1; o.redir = 1'b1; o.npc = pc + imm_j(w);
         end
         OPC_JALR: begin
            if (f3 != 3'd0) o.status = ST_ILLEGAL;
            else begin
               o.res = a + imm_i(w); o.redir = 1'b1; o.npc = {o.res[31:1], 1'b0};
            end
         end
         OPC_LOAD: begin
            if (f3 > 3'd2) o.status = ST_ILLEGAL;
            else o.res = a + imm_i(w);
         end
         OPC_STORE: begin
            if (f3 > 3'd2) o.status = ST_ILLEGAL;
            else o.res = a + imm_s(w);
         end
         OPC_BRANCH: begin
            if (f3 > 3'd1) o.status = ST_ILLEGAL;
            else if ((f3 == 3'd0) == (a == b)) begin
               o.redir = 1'b1; o.npc = pc + imm_b(w);
            end
         end
         OPC_ALUI: begin
            o.wr = 1'b1;
            case (f3)
               3'd0: o.res = a + imm_i(w);
               3'd1: if (f7 != F7_BASE) o.status = ST_ILLEGAL; else o.res = a << sh;
               3'd2: o.res = {31'd0, $signed(a) < $signed(imm_i(w))};
               3'd3: o.res = {31'd0, a < imm_i(w)};
               3'd4: o.res = a ^ imm_i(w);
               3'd5: begin
                  if (f7 == F7_BASE) o.res = a >> sh;
                  else if (f7 == F7_ALT) o.res = $signed(a) >>> sh;
                  else o.status = ST_ILLEGAL;
               end
               3'd6: o.res = a | imm_i(w);
               default: o.res = a & imm_i(w);
            endcase
         end
         OPC_ALUR: begin
            o.wr = 1'b1;
            if (f7 == F7_BASE) begin
               case (f3)
                  3'd0: o.res = a + b;
                  3'd1: o.res = a << b[4:0];
                  3'd2: o.res = {31'd0, $signed(a) < $signed(b)};
                  3'd3: o.res = {31'd0, a < b};
                  3'd4: o.res = a ^ b;
                  3'd5: o.res = a >> b[4:0];
                  3'd6: o.res = a | b;
                  default: o.res = a & b;
               endcase
            end else if (f7 == F7_ALT) begin
               if (f3 == 3'd0) o.res = a - b;
               else if (f3 == 3'd5) o.res = $signed(a) >>> b[4:0];
               else o.status = ST_ILLEGAL;
            end else if (f7 == F7_MULD) begin
               ua = a[31] ? -a : a;
               ub = b[31] ? -b : b;
               case (f3)
                  3'd0: o.res = a * b;
                  3'd1: begin
                     p = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
                     o.res = p[63:32];
                  end
                  3'd2: begin
                     p = {{32{a[31]}}, a} * {32'd0, b};
                     o.res = p[63:32];
                  end
                  3'd3: begin
                     p = {32'd0, a} * {32'd0, b};
                     o.res = p[63:32];
                  end
                  3'd4: begin
                     if (b == 0) o.status = ST_DIVZERO;
                     else begin
                        q = ua / ub;
                        o.res = (a[31] ^ b[31]) ? -q : q;
                     end
                  end
                  3'd6: begin
                     if (b == 0) o.status = ST_DIVZERO;
                     else begin
                        r = ua % ub;
                        o.res = a[31] ? -r : r;
                     end
                  end
                  3'd7: begin
                     if (b == 0) o.status = ST_DIVZERO; else o.res = a % b;
                  end
                  default: o.status = ST_ILLEGAL;
               endcase
            end else o.status = ST_ILLEGAL;
         end
         default: o.status = ST_ILLEGAL;
      endcase
      if (o.status != ST_OK) begin
         o.res = '0; o.wr = 1'b0; o.redir = 1'b0; o.npc = pc + 32'd4;
      end
      return o;
   endfunction

   function automatic logic [31:0] r_type(logic [6:0] f7, logic [2:0] f3);
      return {f7, 5'($urandom), 5'($urandom), f3, 5'($urandom), OPC_ALUR};
   endfunction

   // Random instruction, mostly legal encodings with random fields
   function automatic logic [31:0] rand_instr();
      logic [31:0] w;
      int          pick;
      w = $urandom;
      pick = $urandom_range(0, 99);
      if (pick < 8) w[6:0] = OPC_LUI;
      else if (pick < 14) w[6:0] = OPC_JAL;
      else if (pick < 20) begin
         w[6:0] = OPC_JALR;
         if ($urandom_range(0, 5) != 0) w[14:12] = 3'd0;
      end else if (pick < 28) w[6:0] = OPC_LOAD;
      else if (pick < 35) w[6:0] = OPC_STORE;
      else if (pick < 44) begin
         w[6:0] = OPC_BRANCH;
         if ($urandom_range(0, 4) != 0) w[14:12] = 3'($urandom_range(0, 1));
      end else if (pick < 64) begin
         w[6:0] = OPC_ALUI;
         if ($urandom_range(0, 5) != 0 && (w[14:12] == 3'd1 || w[14:12] == 3'd5))
            w[31:25] = ($urandom_range(0, 1) != 0) ? F7_ALT : F7_BASE;
      end else if (pick < 94) begin
         w[6:0] = OPC_ALUR;
         case ($urandom_range(0, 9))
            0: ;
            1, 2: w[31:25] = F7_BASE;
            3: w[31:25] = F7_ALT;
            default: w[31:25] = F7_MULD;
         endcase
      end
      return w;
   endfunction

   function automatic logic [31:0] rand_operand();
      case ($urandom_range(0, 7))
         0: return 32'd0;
         1: return 32'hFFFF_FFFF;
         2: return 32'h8000_0000;
         3: return 32'h7FFF_FFFF;
         4: return $urandom_range(0, 15);
         default: return $urandom;
      endcase
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycle_count);
      error_count++;
   endtask

   task automatic add_row(logic [31:0] w, logic [31:0] a, logic [31:0] b,
                          logic [31:0] pc, logic has_exp, exec_out_type exp);
      vector_type v;
      v.instr = w; v.a = a; v.b = b; v.pc = pc; v.has_exp = has_exp; v.exp = exp;
      vectors.push_back(v);
   endtask

   function automatic exec_out_type bad(logic [31:0] w, logic [31:0] pc, logic [1:0] st);
      exec_out_type o;
      o.res = '0; o.wr = 1'b0; o.rd = w[11:7]; o.redir = 1'b0;
      o.npc = pc + 32'd4; o.status = st;
      return o;
   endfunction

   // Valid stays high between back-to-back beats; the caller drops it when done
   task automatic send_beat(logic [31:0] w, logic [31:0] a, logic [31:0] b,
                            logic [31:0] pc, logic has_exp, exec_out_type exp);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_instruction <= w; req_src1_data <= a; req_src2_data <= b; req_pc_value <= pc;
      pending_results.push_back(has_exp ? exp : execute_instr(w, a, b, pc));
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   // Result checker
   always @(posedge clock) begin
      exec_out_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected beat", rsp_result_value, 32'd0);
         end else begin
            e = pending_results.pop_front();
            if (rsp_result_value !== e.res) report_mismatch("result", rsp_result_value, e.res);
            if (rsp_writes_register !== e.wr)
               report_mismatch("write", 32'(rsp_writes_register), 32'(e.wr));
            if (rsp_dest_index !== e.rd)
               report_mismatch("rd", 32'(rsp_dest_index), 32'(e.rd));
            if (rsp_redirect !== e.redir)
               report_mismatch("redirect", 32'(rsp_redirect), 32'(e.redir));
            if (rsp_next_pc !== e.npc) report_mismatch("next_pc", rsp_next_pc, e.npc);
            if (rsp_status !== e.status)
               report_mismatch("status", 32'(rsp_status), 32'(e.status));
         end
      end
   end

   // Receiver stall pattern
   always @(negedge clock) begin
      rsp_ready <= !hold_rsp && ($urandom_range(0, 99) >= recv_idle_pct);
   end

   // Cycle limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > MAX_CYC) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin
      exec_out_type x;
      logic [31:0]  w;
      req_valid = 1'b0; req_instruction = '0; req_src1_data = '0;
      req_src2_data = '0; req_pc_value = '0;
      hold_rsp = 1'b0; error_count = 0; cycle_count = 0;
      send_idle_pct = 22; recv_idle_pct = 46;
      reset = 1'b1;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed table: fixed expectations only where obvious
      x = '0;
      w = {20'hFFFFF, 5'd31, OPC_LUI};
      x.res = 32'hFFFFF000; x.wr = 1'b1; x.rd = 5'd31; x.npc = 32'h0; x.status = ST_OK;
      add_row(w, 32'h0, 32'h0, 32'hFFFF_FFFC, 1'b1, x);
      w = 32'h0000_0000;
      add_row(w, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 1'b1, bad(w, 32'h0, ST_ILLEGAL));
      w = 32'hFFFF_FFFF;
      add_row(w, 32'h0, 32'h0, 32'h1234, 1'b1, bad(w, 32'h1234, ST_ILLEGAL));
      w = r_type(F7_MULD, 3'd4);
      add_row(w, 32'h7, 32'h0, 32'h100, 1'b1, bad(w, 32'h100, ST_DIVZERO));
      w = r_type(F7_MULD, 3'd6);
      add_row(w, 32'h8000_0000, 32'h0, 32'h104, 1'b1, bad(w, 32'h104, ST_DIVZERO));
      w = r_type(F7_MULD, 3'd7);
      add_row(w, 32'hFFFF_FFFF, 32'h0, 32'h108, 1'b1, bad(w, 32'h108, ST_DIVZERO));
      w = r_type(F7_MULD, 3'd5);   // DIVU is not supported
      add_row(w, 32'h9, 32'h3, 32'h10C, 1'b1, bad(w, 32'h10C, ST_ILLEGAL));
      // signed overflow on DIV and REM, then every multiply/divide op
      add_row(r_type(F7_MULD, 3'd4), 32'h8000_0000, 32'hFFFF_FFFF, 32'h0, 1'b0, x);
      add_row(r_type(F7_MULD, 3'd6), 32'h8000_0000, 32'hFFFF_FFFF, 32'h0, 1'b0, x);
      for (int f = 0; f < 4; f++)
         add_row(r_type(F7_MULD, 3'(f)), 32'h8000_0000, 32'hFFFF_FFFF, 32'h40, 1'b0, x);
      add_row(r_type(F7_MULD, 3'd7), 32'hFFFF_FFFF, 32'h7, 32'h44, 1'b0, x);
      add_row(r_type(F7_ALT, 3'd5), 32'h8000_0001, 32'h1F, 32'h48, 1'b0, x);
      add_row(r_type(F7_ALT, 3'd0), 32'h0, 32'h1, 32'h4C, 1'b0, x);
      // SRAI, bad shift-immediate, JAL/JALR wrap, bad JALR, taken BEQ/BNE, bad branch, store, bad load
      add_row({F7_ALT, 5'd31, 5'd3, 3'd5, 5'd4, OPC_ALUI}, 32'h8000_0000, 0, 0, 1'b0, x);
      add_row({7'h10, 5'd1, 5'd3, 3'd1, 5'd4, OPC_ALUI}, 32'h1, 0, 0, 1'b0, x);
      add_row({20'h80000, 5'd1, OPC_JAL}, 0, 0, 32'h0, 1'b0, x);
      add_row({12'h7FF, 5'd2, 3'd0, 5'd1, OPC_JALR}, 32'hFFFF_FFFF, 0, 32'h8, 1'b0, x);
      add_row({12'h7FF, 5'd2, 3'd1, 5'd1, OPC_JALR}, 32'h1, 0, 32'h8, 1'b0, x);
      add_row({7'h7F, 5'd2, 5'd1, 3'd0, 5'h1F, OPC_BRANCH}, 5, 5, 32'h0, 1'b0, x);
      add_row({7'h3F, 5'd2, 5'd1, 3'd1, 5'h1E, OPC_BRANCH}, 5, 6, 32'h100, 1'b0, x);
      add_row({7'h3F, 5'd2, 5'd1, 3'd4, 5'h1E, OPC_BRANCH}, 5, 6, 32'h100, 1'b0, x);
      add_row({7'h7F, 5'd2, 5'd1, 3'd2, 5'h1F, OPC_STORE}, 32'h0, 0, 32'h0, 1'b0, x);
      add_row({12'h800, 5'd2, 3'd3, 5'd9, OPC_LOAD}, 32'h10, 0, 32'h0, 1'b0, x);
      foreach (vectors[i])
         send_beat(vectors[i].instr, vectors[i].a, vectors[i].b, vectors[i].pc,
                   vectors[i].has_exp, vectors[i].exp);

      // Receiver holds off long enough for the pipeline to fill and back up
      fork
         begin
            hold_rsp = 1'b1;
            repeat (150) @(posedge clock);
            hold_rsp = 1'b0;
         end
         for (int k = 0; k < 60; k++)
            send_beat(rand_instr(), rand_operand(), rand_operand(), $urandom, 1'b0, x);
      join

      // Sender pauses until the block drains
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);

      for (int k = 0; k < N_RANDOM - 60; k++) begin
         if (k == (N_RANDOM - 60) / 3) begin
            send_idle_pct = 46; recv_idle_pct = 22;
         end else if (k == 2 * (N_RANDOM - 60) / 3) begin
            send_idle_pct = 0; recv_idle_pct = 0;
         end
         send_beat(rand_instr(), rand_operand(), rand_operand(), $urandom, 1'b0, x);
      end

      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (LATENCY + 4) @(negedge clock);
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end
endmodule

>>> sim.f
design/rvdx_pkg.sv
design/rvdx_decode.sv
design/rvdx_mul.sv
design/rvdx_div_step.sv
design/rv32im_decode_execute_unit.sv
test/tb_rv32im_decode_execute_unit.sv
